[hdl/lsst_pkg.sv]
// Shared types, codes and constants for the learning switch with spanning tree.
package lsst_pkg;

    // Fixed field widths
    localparam int MASK_W      = 16;
    localparam int ADDR_W      = 8;
    localparam int PORT_W      = 4;
    localparam int ID_W        = 8;
    localparam int DIST_W      = 8;
    localparam int MODE_W      = 2;
    localparam int STYPE_W     = 2;
    localparam int NPORTS_W    = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    // Parameter defaults
    localparam int NUM_PORTS_DEF  = 16;
    localparam int ADDR_COUNT_DEF = 256;

    // Register reset values
    localparam logic [ID_W-1:0]     NODE_ID_RESET   = 8'd0;
    localparam logic [NPORTS_W-1:0] NUM_PORTS_RESET = 5'd16;
    localparam logic [DIST_W-1:0]   DIST_MAX        = 8'd255;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_DATA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CTRL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

    // Sender types
    localparam logic [STYPE_W-1:0] STYPE_SWITCH = 2'd0;
    localparam logic [STYPE_W-1:0] STYPE_HOST   = 2'd1;
    localparam logic [STYPE_W-1:0] STYPE_END    = 2'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_BEACON = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_PORTS = 1'd1;

    // Tree/root state seen by the datapath
    typedef struct packed {
        logic [ID_W-1:0]     root_id;
        logic [DIST_W-1:0]   root_dist;
        logic [PORT_W-1:0]   parent_port;
        logic                parent_valid;
        logic [MASK_W-1:0]   tree;
        logic [NPORTS_W-1:0] act_n;
        logic [MASK_W-1:0]   act_mask;
    } lsst_state_t;

endpackage

[hdl/lsst_addr_table.sv]
// Address learning table: one RAM, clearing sweep after reset, registered reads with bypass.
module lsst_addr_table #(
    parameter int ADDR_COUNT = lsst_pkg::ADDR_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [lsst_pkg::ADDR_W-1:0]  src_addr,
    input  logic [lsst_pkg::ADDR_W-1:0]  dst_addr,
    input  logic                         wr_en,
    input  logic [lsst_pkg::MASK_W-1:0]  wr_data,
    output logic [lsst_pkg::MASK_W-1:0]  src_data,
    output logic [lsst_pkg::MASK_W-1:0]  dst_data,
    output logic                         same_row,
    output logic                         busy
);

    localparam int AW = (ADDR_COUNT > 1) ? $clog2(ADDR_COUNT) : 1;
    localparam int MW = 17;

    // address modulo table size: 4 restoring steps, quotient < 16
    function automatic logic [AW-1:0] row_of(input logic [lsst_pkg::ADDR_W-1:0] a);
        logic [MW-1:0] r;
        r = MW'(a);
        for (int k = 3; k >= 0; k--) begin
            if (r >= (MW'(ADDR_COUNT) << k)) begin
                r = r - (MW'(ADDR_COUNT) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    logic [lsst_pkg::MASK_W-1:0] mem [ADDR_COUNT];

    logic [AW-1:0]               src_row_reg;
    logic [AW-1:0]               dst_row_reg;
    logic [lsst_pkg::MASK_W-1:0] src_rd_reg;
    logic [lsst_pkg::MASK_W-1:0] dst_rd_reg;
    logic                        src_byp_reg;
    logic                        dst_byp_reg;
    logic [lsst_pkg::MASK_W-1:0] byp_data_reg;
    logic                        clr_reg;
    logic                        clr_next;
    logic [AW-1:0]               clr_cnt_reg;
    logic [AW-1:0]               clr_cnt_next;

    logic [AW-1:0]               rd_src_row;
    logic [AW-1:0]               rd_dst_row;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [lsst_pkg::MASK_W-1:0] mem_wdata;

    assign rd_src_row = row_of(src_addr);
    assign rd_dst_row = row_of(dst_addr);

    always_comb
    begin
        mem_we    = wr_en;
        mem_waddr = src_row_reg;
        mem_wdata = wr_data;
        if (clr_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
    end

    always_comb
    begin
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        if (clr_reg)
        begin
            if (clr_cnt_reg == AW'(ADDR_COUNT - 1))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // RAM: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            src_rd_reg <= mem[rd_src_row];
            dst_rd_reg <= mem[rd_dst_row];
        end
    end

    // same-edge write bypass and row capture
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            src_row_reg  <= rd_src_row;
            dst_row_reg  <= rd_dst_row;
            src_byp_reg  <= wr_en && (src_row_reg == rd_src_row);
            dst_byp_reg  <= wr_en && (src_row_reg == rd_dst_row);
            byp_data_reg <= wr_data;
        end
    end

    assign src_data = src_byp_reg ? byp_data_reg : src_rd_reg;
    assign dst_data = dst_byp_reg ? byp_data_reg : dst_rd_reg;
    assign same_row = (src_row_reg == dst_row_reg);
    assign busy     = clr_reg;

endmodule

[hdl/lsst_tree_state.sv]
// Configuration registers, root election and per-port tree flags.
module lsst_tree_state #(
    parameter int NUM_PORTS = lsst_pkg::NUM_PORTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lsst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsst_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              upd,
    input  logic [lsst_pkg::PORT_W-1:0]       rx_port,
    input  logic [lsst_pkg::ADDR_W-1:0]       src_addr,
    input  logic [lsst_pkg::ID_W-1:0]         sender_root_id,
    input  logic [lsst_pkg::DIST_W-1:0]       sender_root_dist,
    input  logic [lsst_pkg::STYPE_W-1:0]      sender_type,
    input  logic                              sender_is_child,
    output lsst_pkg::lsst_state_t             st
);

    localparam int LANES = (NUM_PORTS < lsst_pkg::MASK_W) ? NUM_PORTS : lsst_pkg::MASK_W;

    logic [lsst_pkg::ID_W-1:0]     node_id_reg;
    logic [lsst_pkg::NPORTS_W-1:0] num_ports_reg;
    logic [lsst_pkg::ID_W-1:0]     root_id_reg;
    logic [lsst_pkg::ID_W-1:0]     root_id_next;
    logic [lsst_pkg::DIST_W-1:0]   root_dist_reg;
    logic [lsst_pkg::DIST_W-1:0]   root_dist_next;
    logic [lsst_pkg::PORT_W-1:0]   parent_port_reg;
    logic [lsst_pkg::PORT_W-1:0]   parent_port_next;
    logic                          parent_valid_reg;
    logic                          parent_valid_next;
    logic [LANES-1:0]              tree_reg;
    logic [LANES-1:0]              tree_next;

    logic [lsst_pkg::MASK_W-1:0]   tree_w;
    logic [lsst_pkg::MASK_W-1:0]   rx_oh;
    logic [lsst_pkg::DIST_W:0]     nd;
    logic [lsst_pkg::DIST_W-1:0]   sat;
    logic                          take;
    logic                          keep;
    logic                          tval;
    logic [lsst_pkg::NPORTS_W-1:0] act_n;
    logic [lsst_pkg::MASK_W-1:0]   act_mask;

    assign tree_w = lsst_pkg::MASK_W'(tree_reg);
    assign rx_oh  = lsst_pkg::MASK_W'(1) << rx_port;
    assign nd     = {1'b0, sender_root_dist} + 1'b1;
    assign sat    = nd[lsst_pkg::DIST_W] ? lsst_pkg::DIST_MAX : nd[lsst_pkg::DIST_W-1:0];

    // active port count: 0 acts as 1, clamp at lane count
    always_comb
    begin
        if (num_ports_reg == '0)
        begin
            act_n = lsst_pkg::NPORTS_W'(1);
        end
        else if (num_ports_reg > lsst_pkg::NPORTS_W'(LANES))
        begin
            act_n = lsst_pkg::NPORTS_W'(LANES);
        end
        else
        begin
            act_n = num_ports_reg;
        end
        for (int i = 0; i < lsst_pkg::MASK_W; i++)
        begin
            act_mask[i] = (lsst_pkg::NPORTS_W'(i) < act_n);
        end
    end

    // root election and tree flag update
    always_comb
    begin
        take = 1'b0;
        if (sender_type == lsst_pkg::STYPE_SWITCH)
        begin
            if (sender_root_id < root_id_reg)
            begin
                take = 1'b1;
            end
            else if (sender_root_id == root_id_reg)
            begin
                take = ({1'b0, root_dist_reg} > nd) ||
                       (({1'b0, root_dist_reg} == nd) && parent_valid_reg &&
                        (rx_port < parent_port_reg));
            end
        end

        root_id_next      = root_id_reg;
        root_dist_next    = root_dist_reg;
        parent_port_next  = parent_port_reg;
        parent_valid_next = parent_valid_reg;
        if (upd && take)
        begin
            root_id_next      = sender_root_id;
            root_dist_next    = sat;
            parent_port_next  = rx_port;
            parent_valid_next = 1'b1;
        end

        // kept only toward a lower-id neighbor one hop closer to the root
        keep = (root_dist_next != '0) && (nd == {1'b0, root_dist_next}) &&
               (src_addr < node_id_reg);

        case (sender_type)
            lsst_pkg::STYPE_HOST:   tval = 1'b1;
            lsst_pkg::STYPE_END:    tval = 1'b1;
            lsst_pkg::STYPE_SWITCH: tval = sender_is_child || (tree_w[rx_port] && keep);
            default:                tval = 1'b0;
        endcase

        tree_next = tree_reg;
        if (upd)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                if (rx_oh[i])
                begin
                    tree_next[i] = tval;
                end
            end
        end

        // node id write restarts the election
        if (cfg_we && (cfg_index == lsst_pkg::REG_NODE_ID))
        begin
            root_id_next      = cfg_data;
            root_dist_next    = '0;
            parent_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg      <= lsst_pkg::NODE_ID_RESET;
            num_ports_reg    <= lsst_pkg::NUM_PORTS_RESET;
            root_id_reg      <= lsst_pkg::NODE_ID_RESET;
            root_dist_reg    <= '0;
            parent_port_reg  <= '0;
            parent_valid_reg <= 1'b0;
            tree_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    lsst_pkg::REG_NODE_ID:   node_id_reg   <= cfg_data;
                    lsst_pkg::REG_NUM_PORTS: num_ports_reg <= cfg_data[lsst_pkg::NPORTS_W-1:0];
                    default: ;
                endcase
            end
            root_id_reg      <= root_id_next;
            root_dist_reg    <= root_dist_next;
            parent_port_reg  <= parent_port_next;
            parent_valid_reg <= parent_valid_next;
            tree_reg         <= tree_next;
        end
    end

    assign st.root_id      = root_id_reg;
    assign st.root_dist    = root_dist_reg;
    assign st.parent_port  = parent_port_reg;
    assign st.parent_valid = parent_valid_reg;
    assign st.tree         = tree_w;
    assign st.act_n        = act_n;
    assign st.act_mask     = act_mask;

endmodule

[hdl/learning_switch_spanning_tree.sv]
// Top level: input stage, forwarding decision, beacon sequencing and result register.
//
//  channel | valid / ready        | payload
//  --------+----------------------+----------------------------------------------------
//  in      | in_valid / in_ready  | mode rx_port src_addr dst_addr sender_root_id
//          |                      | sender_root_dist sender_type sender_is_child
//  out     | out_valid / out_ready| kind out_port_mask beacon_root_id beacon_root_dist
//          |                      | beacon_is_child last
//  cfg     | cfg_valid / cfg_ready| cfg_index cfg_data  (0 node id, 1 num_ports)
//
// A word is registered in the input stage, where the address RAM read happens; there it
// is decided and loads the result register. Control words sustain one word per cycle, data
// words too while the result register is free; a tick holds the input stage until it has
// sent one beacon per active port (1..16). After reset the address RAM is swept to zero
// with in_ready low; config writes are always taken (cfg_ready is tied high).
// A stalled result only holds back the input stage when it has a result to deliver.
module learning_switch_spanning_tree #(
    parameter int NUM_PORTS  = lsst_pkg::NUM_PORTS_DEF,
    parameter int ADDR_COUNT = lsst_pkg::ADDR_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lsst_pkg::MODE_W-1:0]      mode,
    input  logic [lsst_pkg::PORT_W-1:0]      rx_port,
    input  logic [lsst_pkg::ADDR_W-1:0]      src_addr,
    input  logic [lsst_pkg::ADDR_W-1:0]      dst_addr,
    input  logic [lsst_pkg::ID_W-1:0]        sender_root_id,
    input  logic [lsst_pkg::DIST_W-1:0]      sender_root_dist,
    input  logic [lsst_pkg::STYPE_W-1:0]     sender_type,
    input  logic                             sender_is_child,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             kind,
    output logic [lsst_pkg::MASK_W-1:0]      out_port_mask,
    output logic [lsst_pkg::ID_W-1:0]        beacon_root_id,
    output logic [lsst_pkg::DIST_W-1:0]      beacon_root_dist,
    output logic                             beacon_is_child,
    output logic                             last,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lsst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsst_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // input stage
    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [lsst_pkg::MODE_W-1:0]     s1_mode_reg;
    logic [lsst_pkg::PORT_W-1:0]     s1_rx_reg;
    logic [lsst_pkg::ADDR_W-1:0]     s1_src_reg;
    logic [lsst_pkg::ID_W-1:0]       s1_srid_reg;
    logic [lsst_pkg::DIST_W-1:0]     s1_srd_reg;
    logic [lsst_pkg::STYPE_W-1:0]    s1_stype_reg;
    logic                            s1_child_reg;
    logic [lsst_pkg::PORT_W-1:0]     beat_reg;
    logic [lsst_pkg::PORT_W-1:0]     beat_next;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            kind_reg;
    logic [lsst_pkg::MASK_W-1:0]     mask_reg;
    logic [lsst_pkg::ID_W-1:0]       rid_reg;
    logic [lsst_pkg::DIST_W-1:0]     rdist_reg;
    logic                            child_reg;
    logic                            last_reg;

    lsst_pkg::lsst_state_t           st;
    logic [lsst_pkg::MASK_W-1:0]     src_data;
    logic [lsst_pkg::MASK_W-1:0]     dst_data;
    logic                            same_row;
    logic                            tbl_busy;

    logic                            accept;
    logic                            rx_ok;
    logic                            is_data;
    logic                            is_ctrl;
    logic                            is_tick;
    logic                            out_free;
    logic                            emit;
    logic                            beat_last;
    logic                            s1_done;
    logic [lsst_pkg::MASK_W-1:0]     rx_oh;
    logic [lsst_pkg::MASK_W-1:0]     new_src;
    logic [lsst_pkg::MASK_W-1:0]     dst_row;
    logic [lsst_pkg::MASK_W-1:0]     known;
    logic [lsst_pkg::MASK_W-1:0]     src_act;
    logic [lsst_pkg::MASK_W-1:0]     sender_oh;
    logic [lsst_pkg::MASK_W-1:0]     data_mask;

    // ---- word classification in the input stage ----
    assign rx_ok   = ({1'b0, s1_rx_reg} < st.act_n);
    assign is_data = (s1_mode_reg == lsst_pkg::MODE_DATA) && rx_ok;
    assign is_ctrl = (s1_mode_reg == lsst_pkg::MODE_CTRL) && rx_ok;
    assign is_tick = (s1_mode_reg == lsst_pkg::MODE_TICK);

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = s1_valid_reg && out_free && (is_data || is_tick);
    assign beat_last = (({1'b0, beat_reg} + 1'b1) == st.act_n);

    // data and tick words wait for the result register; others retire at once
    always_comb
    begin
        if (is_data)
        begin
            s1_done = emit;
        end
        else if (is_tick)
        begin
            s1_done = emit && beat_last;
        end
        else
        begin
            s1_done = s1_valid_reg;
        end
    end

    assign in_ready = !tbl_busy && (!s1_valid_reg || s1_done);
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign s1_valid_next = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);

    always_comb
    begin
        beat_next = beat_reg;
        if (emit && is_tick)
        begin
            beat_next = beat_last ? '0 : beat_reg + 1'b1;
        end
    end

    // ---- forwarding decision ----
    // learn src on rx first; dst row sees that bit when both map to one row
    always_comb
    begin
        rx_oh     = lsst_pkg::MASK_W'(1) << s1_rx_reg;
        new_src   = src_data | rx_oh;
        dst_row   = same_row ? new_src : dst_data;
        known     = dst_row & st.act_mask;
        src_act   = new_src & st.act_mask;
        sender_oh = src_act & (~src_act + 1'b1);
        if (known != '0)
        begin
            data_mask = known & (~known + 1'b1);    // lowest port that knows dst
        end
        else
        begin
            data_mask = st.tree & st.act_mask & ~sender_oh;   // flood
        end
    end

    // ---- result register ----
    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= mode;
            s1_rx_reg    <= rx_port;
            s1_src_reg   <= src_addr;
            s1_srid_reg  <= sender_root_id;
            s1_srd_reg   <= sender_root_dist;
            s1_stype_reg <= sender_type;
            s1_child_reg <= sender_is_child;
        end
        if (emit)
        begin
            if (is_tick)
            begin
                kind_reg  <= lsst_pkg::KIND_BEACON;
                mask_reg  <= lsst_pkg::MASK_W'(1) << beat_reg;
                rid_reg   <= st.root_id;
                rdist_reg <= st.root_dist;
                child_reg <= st.parent_valid && (st.parent_port == beat_reg);
                last_reg  <= beat_last;
            end
            else
            begin
                kind_reg  <= lsst_pkg::KIND_DATA;
                mask_reg  <= data_mask;
                rid_reg   <= '0;
                rdist_reg <= '0;
                child_reg <= 1'b0;
                last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign out_port_mask    = mask_reg;
    assign beacon_root_id   = rid_reg;
    assign beacon_root_dist = rdist_reg;
    assign beacon_is_child  = child_reg;
    assign last             = last_reg;

    // ---- sub-blocks ----
    lsst_addr_table #(
        .ADDR_COUNT (ADDR_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .src_addr (src_addr),
        .dst_addr (dst_addr),
        .wr_en    (emit && is_data),
        .wr_data  (new_src),
        .src_data (src_data),
        .dst_data (dst_data),
        .same_row (same_row),
        .busy     (tbl_busy)
    );

    lsst_tree_state #(
        .NUM_PORTS (NUM_PORTS)
    ) u_tree (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .upd              (s1_valid_reg && is_ctrl),
        .rx_port          (s1_rx_reg),
        .src_addr         (s1_src_reg),
        .sender_root_id   (s1_srid_reg),
        .sender_root_dist (s1_srd_reg),
        .sender_type      (s1_stype_reg),
        .sender_is_child  (s1_child_reg),
        .st               (st)
    );

endmodule
